### hw/rtl/lsa_pkg.sv
package lsa_pkg;

	localparam int LED_COUNT = 16;

	localparam int IDX_W     = 5;
	localparam int CNT_W     = 6;
	localparam int COLOR_W   = 24;
	localparam int PAT_W     = 4;
	localparam int SEC_W     = 16;
	localparam int ELAPSED_W = 26;
	localparam int ALU_W     = 32;
	localparam int LED_AW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
	localparam int MS_PER_SEC = 1000;

	localparam int BLINK_FAST_MS = 150;
	localparam int BLINK_SLOW_MS = 500;
	localparam int CHASE_FAST_MS = 30;
	localparam int CHASE_SLOW_MS = 150;
	localparam int PULSE_SHORT_MS = 20;
	localparam int PULSE_LONG_MS  = 300;

	// quotient of a bar is below LED_COUNT, so this many restoring steps cover it
	localparam int DIV_STEPS = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	localparam logic [PAT_W-1:0] PAT_SOLID       = 4'd0;
	localparam logic [PAT_W-1:0] PAT_BLINK_FAST  = 4'd1;
	localparam logic [PAT_W-1:0] PAT_BLINK_SLOW  = 4'd2;
	localparam logic [PAT_W-1:0] PAT_CHASE_FAST  = 4'd3;
	localparam logic [PAT_W-1:0] PAT_CHASE_SLOW  = 4'd4;
	localparam logic [PAT_W-1:0] PAT_PULSE_SHORT = 4'd5;
	localparam logic [PAT_W-1:0] PAT_PULSE_LONG  = 4'd6;
	localparam logic [PAT_W-1:0] PAT_DRAIN_BAR   = 4'd7;
	localparam logic [PAT_W-1:0] PAT_FILL_BAR    = 4'd8;

	// frame to show: first cnt LEDs lit, or only the LED at pos
	typedef struct packed {
		logic             single;
		logic [CNT_W-1:0] cnt;
		logic [IDX_W-1:0] pos;
	} want_t;

endpackage

### hw/rtl/lsa_alu.sv
module lsa_alu (
	input  logic [lsa_pkg::ALU_W-1:0] a,
	input  logic [lsa_pkg::ALU_W-1:0] b,
	output logic                      ge,
	output logic [lsa_pkg::ALU_W-1:0] diff
);
	import lsa_pkg::*;

	logic [ALU_W:0] sub;

	assign sub  = {1'b0, a} - {1'b0, b};
	assign ge   = ~sub[ALU_W];
	assign diff = sub[ALU_W-1:0];

endmodule

### hw/rtl/lsa_frame.sv
module lsa_frame (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lsa_pkg::IDX_W-1:0]   idx,
	input  lsa_pkg::want_t              want,
	input  logic [lsa_pkg::COLOR_W-1:0] color,
	input  logic                        wr_en,
	output logic [lsa_pkg::COLOR_W-1:0] want_color,
	output logic                        match
);
	import lsa_pkg::*;

	logic [COLOR_W-1:0] shown_q [LED_COUNT];
	logic               on;
	logic [LED_AW-1:0]  addr;

	assign addr = idx[LED_AW-1:0];

	always_comb begin
		if (want.single) begin
			on = (idx == want.pos);
		end else begin
			on = ({1'b0, idx} < want.cnt);
		end
		want_color = on ? color : '0;
		match      = (shown_q[addr] == want_color);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LED_COUNT; i++) begin
				shown_q[i] <= '0;
			end
		end else if (wr_en) begin
			shown_q[addr] <= want_color;
		end
	end

endmodule

### hw/rtl/led_strip_animation_engine_unit.sv
// Steps: a tick while lit enters the evaluation; a running bar then runs the restoring divide,
// the compare walks the shown frame until an LED differs, then the whole frame is emitted from
// LED 0. A set emits a dark clearing frame, then with turn_on the same compare/emit for the
// pattern's first frame; an output stall holds the emit. Throughput: one item at a time;
// input stalls until the last LED is loaded into the output register, the frame is unchanged
// or no step is due. Reset (arst_n low, async): state and frame zero, output data not reset.
module led_strip_animation_engine_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        op,
	input  logic                        turn_on,
	input  logic [lsa_pkg::COLOR_W-1:0] rgb_color,
	input  logic [lsa_pkg::PAT_W-1:0]   pattern,
	input  logic [lsa_pkg::SEC_W-1:0]   bar_seconds,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lsa_pkg::IDX_W-1:0]   led_index,
	output logic [lsa_pkg::COLOR_W-1:0] led_color,
	output logic                        frame_end
);
	import lsa_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]           state_q;
	logic                 lit_q;
	logic [COLOR_W-1:0]   cur_color_q;
	logic [PAT_W-1:0]     cur_pattern_q;
	logic [ELAPSED_W-1:0] total_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic                 blink_phase_q;
	logic [IDX_W-1:0]     chase_pos_q;
	logic [CNT_W-1:0]     bar_count_q;
	want_t                want_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 init_pend_q;
	logic [ALU_W-1:0]     num_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [STEP_W-1:0]    step_q;

	logic                 out_valid_q;
	logic [IDX_W-1:0]     led_index_q;
	logic [COLOR_W-1:0]   led_color_q;
	logic                 frame_end_q;

	logic [ELAPSED_W-1:0] interval;
	logic                 is_bar;
	logic                 is_fill;
	logic [ALU_W-1:0]     alu_a;
	logic [ALU_W-1:0]     alu_b;
	logic                 alu_ge;
	logic [ALU_W-1:0]     alu_diff;
	logic [DIV_STEPS-1:0] quo_next;
	logic [CNT_W-1:0]     grown;
	logic [CNT_W-1:0]     bar_div_cnt;
	logic [CNT_W-1:0]     bar_full_cnt;
	logic [CNT_W-1:0]     chase_inc;
	logic [IDX_W-1:0]     chase_next;
	logic [CNT_W-1:0]     init_cnt;
	logic                 can_load;
	logic                 emit_fire;
	logic                 last_led;
	logic [COLOR_W-1:0]   want_color;
	logic                 match;

	always_comb begin
		unique case (cur_pattern_q)
			PAT_BLINK_FAST:  interval = ELAPSED_W'(BLINK_FAST_MS);
			PAT_BLINK_SLOW:  interval = ELAPSED_W'(BLINK_SLOW_MS);
			PAT_CHASE_FAST:  interval = ELAPSED_W'(CHASE_FAST_MS);
			PAT_CHASE_SLOW:  interval = ELAPSED_W'(CHASE_SLOW_MS);
			PAT_PULSE_SHORT: interval = ELAPSED_W'(PULSE_SHORT_MS);
			PAT_PULSE_LONG:  interval = ELAPSED_W'(PULSE_LONG_MS);
			default:         interval = '0;
		endcase
	end

	assign is_fill = (cur_pattern_q == PAT_FILL_BAR);
	assign is_bar  = is_fill || (cur_pattern_q == PAT_DRAIN_BAR);

	// one compare/subtract serves interval checks, bar completion and the divide steps
	always_comb begin
		if (state_q == ST_DIV) begin
			alu_a = num_q;
			alu_b = ALU_W'(total_q) << step_q;
		end else if (is_bar) begin
			alu_a = ALU_W'(elapsed_q);
			alu_b = ALU_W'(total_q);
		end else begin
			alu_a = ALU_W'(interval);
			alu_b = ALU_W'(elapsed_q);
		end
	end

	lsa_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.ge   (alu_ge),
		.diff (alu_diff)
	);

	assign quo_next     = (quo_q << 1) | DIV_STEPS'(alu_ge);
	assign grown        = CNT_W'(quo_next);
	assign bar_div_cnt  = is_fill ? grown : CNT_W'(LED_COUNT) - grown;
	assign bar_full_cnt = is_fill ? CNT_W'(LED_COUNT) : '0;
	assign chase_inc    = {1'b0, chase_pos_q} + CNT_W'(1);
	assign chase_next   = (chase_inc >= CNT_W'(LED_COUNT)) ? '0 : chase_inc[IDX_W-1:0];
	assign init_cnt     = ((cur_pattern_q == PAT_SOLID) || (cur_pattern_q == PAT_PULSE_SHORT)
	                    || (cur_pattern_q == PAT_PULSE_LONG) || (cur_pattern_q == PAT_DRAIN_BAR))
	                    ? CNT_W'(LED_COUNT) : '0;

	assign can_load  = !out_valid_q || !out_stall;
	assign emit_fire = (state_q == ST_EMIT) && can_load;
	assign last_led  = (idx_q == IDX_W'(LED_COUNT - 1));

	lsa_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.idx        (idx_q),
		.want       (want_q),
		.color      (cur_color_q),
		.wr_en      (emit_fire),
		.want_color (want_color),
		.match      (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			lit_q         <= 1'b0;
			cur_color_q   <= '0;
			cur_pattern_q <= PAT_SOLID;
			total_q       <= '0;
			elapsed_q     <= '0;
			blink_phase_q <= 1'b0;
			chase_pos_q   <= '0;
			bar_count_q   <= '0;
			want_q        <= '0;
			idx_q         <= '0;
			init_pend_q   <= 1'b0;
			num_q         <= '0;
			quo_q         <= '0;
			step_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q <= '0;
						if (op == OP_SET) begin
							lit_q         <= turn_on;
							cur_color_q   <= rgb_color;
							cur_pattern_q <= pattern;
							total_q       <= ELAPSED_W'(bar_seconds * ELAPSED_W'(MS_PER_SEC));
							elapsed_q     <= '0;
							blink_phase_q <= (pattern == PAT_BLINK_FAST);
							chase_pos_q   <= '0;
							bar_count_q   <= (pattern == PAT_DRAIN_BAR) ? CNT_W'(LED_COUNT) : '0;
							want_q        <= '0;
							init_pend_q   <= 1'b1;
							state_q       <= ST_EMIT;
						end else if (lit_q) begin
							if (elapsed_q != ELAPSED_MAX) begin
								elapsed_q <= elapsed_q + ELAPSED_W'(1);
							end
							state_q <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					priority if (is_bar) begin
						if (alu_ge) begin
							bar_count_q <= bar_full_cnt;
							want_q      <= '{single: 1'b0, cnt: bar_full_cnt, pos: '0};
							state_q     <= ST_CMP;
						end else begin
							num_q   <= ALU_W'(elapsed_q) * ALU_W'(LED_COUNT);
							quo_q   <= '0;
							step_q  <= STEP_W'(DIV_STEPS - 1);
							state_q <= ST_DIV;
						end
					end else if (interval != '0 && !alu_ge) begin
						// elapsed passed the interval: step the pattern (a pulse turns off)
						state_q <= ST_CMP;
						if (cur_pattern_q == PAT_BLINK_FAST || cur_pattern_q == PAT_BLINK_SLOW) begin
							elapsed_q     <= '0;
							blink_phase_q <= !blink_phase_q;
							want_q        <= '{single: 1'b0,
							                   cnt: blink_phase_q ? '0 : CNT_W'(LED_COUNT),
							                   pos: '0};
						end else if (cur_pattern_q == PAT_CHASE_FAST
						             || cur_pattern_q == PAT_CHASE_SLOW) begin
							elapsed_q   <= '0;
							chase_pos_q <= chase_next;
							want_q      <= '{single: 1'b1, cnt: '0, pos: chase_next};
						end else begin
							lit_q  <= 1'b0;
							want_q <= '0;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					quo_q <= quo_next;
					if (alu_ge) begin
						num_q <= alu_diff;
					end
					if (step_q == '0) begin
						bar_count_q <= bar_div_cnt;
						want_q      <= '{single: 1'b0, cnt: bar_div_cnt, pos: '0};
						state_q     <= ST_CMP;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_CMP: begin
					if (!match) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else if (last_led) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_EMIT: begin
					if (can_load) begin
						if (!last_led) begin
							idx_q <= idx_q + IDX_W'(1);
						end else if (init_pend_q && lit_q) begin
							// clearing frame done: check the first frame of the pattern
							init_pend_q <= 1'b0;
							idx_q       <= '0;
							want_q      <= '{single: 1'b0, cnt: init_cnt, pos: '0};
							state_q     <= ST_CMP;
						end else begin
							init_pend_q <= 1'b0;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			led_index_q <= idx_q;
			led_color_q <= want_color;
			frame_end_q <= last_led;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign led_index = led_index_q;
	assign led_color = led_color_q;
	assign frame_end = frame_end_q;

endmodule

### hw/rtl/lsa_checker.sv
module lsa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        op,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [lsa_pkg::IDX_W-1:0]   led_index,
	input logic [lsa_pkg::COLOR_W-1:0] led_color,
	input logic                        frame_end
);
	import lsa_pkg::*;

	// the last LED of a frame is the one that closes it
	a_frame_end_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> led_index == IDX_W'(LED_COUNT - 1))
		else $error("frame_end on wrong LED");

	// items of one frame follow back to back in LED order
	a_frame_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !frame_end
		|=> out_valid && led_index == $past(led_index) + IDX_W'(1))
		else $error("frame broken off or out of order");

	// a set command always produces a clearing frame, so input stalls next
	a_set_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == OP_SET |=> in_stall)
		else $error("set command did not start a frame");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(led_color) && $stable(led_index))
		else $error("stalled item changed");

endmodule

bind led_strip_animation_engine_unit lsa_checker u_lsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.op        (op),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.led_index (led_index),
	.led_color (led_color),
	.frame_end (frame_end)
);
